### sv/thct_pkg.sv
// Shared types and constants for the tiered hotness counter table.
// No dependencies; every other file in the project imports this package.
package thct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIER1_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIER2_LIMIT = 1'd1;

  localparam logic [COUNT_W-1:0] TIER1_LIMIT_RST = 16'd1000;
  localparam logic [COUNT_W-1:0] TIER2_LIMIT_RST = 16'd10000;

  // Execution modes, also the tier codes held in the table.
  localparam logic [MODE_W-1:0] MODE_INTERP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIER1  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIER2  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FULL   = 2'd3;

  // Promotion codes.
  localparam logic [MODE_W-1:0] PROMO_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] PROMO_TIER1 = 2'd1;
  localparam logic [MODE_W-1:0] PROMO_TIER2 = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  tier;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_key;   // capture the key and restart the scan
    logic scan;       // issue the next key read
    logic rd_entry;   // key matched: fetch the entry of the matched slot
    logic insert;     // key absent: store it in the next free slot
    logic update;     // count, promote, write back and present the result
    logic reject;     // table full: present a rejected result
  } thct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic miss;
    logic full;
  } thct_status_t;

endpackage

### sv/thct_ctrl.sv
// Controller state machine of the tiered hotness counter table.
// Depends on thct_pkg for the command and status structs.
module thct_ctrl
  import thct_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  thct_status_t status,
  output thct_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_key = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.rd_entry = 1'b1;
          state_nxt    = ST_UPDATE;
        end else if (status.miss) begin
          if (status.full) begin
            cmd.reject = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.insert = 1'b1;
            state_nxt  = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### sv/thct_datapath.sv
// Datapath of the tiered hotness counter table: key and entry memories,
// scan pipeline, occupancy count, limit registers and result registers.
// Depends on thct_pkg; driven by thct_ctrl through thct_cmd_t.
module thct_datapath
  import thct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  thct_cmd_t             cmd,
  output thct_status_t          status,
  input  logic [KEY_W-1:0]      in_method_key,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [MODE_W-1:0]     out_exec_mode,
  output logic [MODE_W-1:0]     out_promoted_to,
  output logic [COUNT_W-1:0]    out_call_count,
  output logic [SLOT_W-1:0]     out_entry_slot,
  output logic                  out_was_inserted
);

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  entry_t           ent_mem [TABLE_DEPTH];

  logic [KEY_W-1:0]   key_r;
  logic [CNT_W-1:0]   entries_used_r;
  logic [CNT_W-1:0]   scan_idx_r;
  logic               cmp_v_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [KEY_W-1:0]   key_rd_r;
  entry_t             ent_rd_r;
  logic [IDX_W-1:0]   slot_r;
  logic               ins_r;
  logic [COUNT_W-1:0] tier1_limit_r;
  logic [COUNT_W-1:0] tier2_limit_r;

  logic               out_valid_r;
  logic [MODE_W-1:0]  out_mode_r;
  logic [MODE_W-1:0]  out_promo_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_ins_r;

  logic               issue;
  logic [COUNT_W-1:0] old_count;
  logic [COUNT_W-1:0] new_count;
  logic [MODE_W-1:0]  cur_mode;
  logic [MODE_W-1:0]  new_tier;
  logic [MODE_W-1:0]  promo;

  assign issue = cmd.scan && (scan_idx_r < entries_used_r);

  assign status.hit  = cmp_v_r && (key_rd_r == key_r);
  assign status.miss = !cmp_v_r && (scan_idx_r == entries_used_r);
  assign status.full = (entries_used_r == CNT_W'(TABLE_DEPTH));

  // A freshly inserted entry starts at count zero, tier zero.
  assign old_count = ins_r ? '0 : ent_rd_r.count;
  assign cur_mode  = ins_r ? MODE_INTERP : ent_rd_r.tier;
  assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;

  always_comb begin
    new_tier = cur_mode;
    promo    = PROMO_NONE;
    case (cur_mode)
      MODE_INTERP: begin
        if (new_count >= tier1_limit_r) begin
          new_tier = MODE_TIER1;
          promo    = PROMO_TIER1;
        end
      end
      MODE_TIER1: begin
        if (new_count >= tier2_limit_r) begin
          new_tier = MODE_TIER2;
          promo    = PROMO_TIER2;
        end
      end
      default: begin
        new_tier = cur_mode;
      end
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (issue) begin
      key_rd_r <= key_mem[scan_idx_r[IDX_W-1:0]];
    end
    if (cmd.insert) begin
      key_mem[entries_used_r[IDX_W-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_entry) begin
      ent_rd_r <= ent_mem[cmp_idx_r];
    end
    if (cmd.update) begin
      ent_mem[slot_r] <= '{tier: new_tier, count: new_count};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= in_method_key;
    end
    if (issue) begin
      cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    if (cmd.rd_entry) begin
      slot_r <= cmp_idx_r;
      ins_r  <= 1'b0;
    end else if (cmd.insert) begin
      slot_r <= entries_used_r[IDX_W-1:0];
      ins_r  <= 1'b1;
    end
    if (cmd.update) begin
      out_mode_r  <= cur_mode;
      out_promo_r <= promo;
      out_count_r <= new_count;
      out_slot_r  <= SLOT_W'(slot_r);
      out_ins_r   <= ins_r;
    end else if (cmd.reject) begin
      out_mode_r  <= MODE_FULL;
      out_promo_r <= PROMO_NONE;
      out_count_r <= '0;
      out_slot_r  <= '0;
      out_ins_r   <= 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= '0;
      scan_idx_r     <= '0;
      cmp_v_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      tier1_limit_r  <= TIER1_LIMIT_RST;
      tier2_limit_r  <= TIER2_LIMIT_RST;
    end else begin
      out_valid_r <= cmd.update || cmd.reject;
      if (cmd.load_key) begin
        scan_idx_r <= '0;
        cmp_v_r    <= 1'b0;
      end else if (cmd.scan) begin
        cmp_v_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
      if (cmd.insert) begin
        entries_used_r <= entries_used_r + 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TIER1_LIMIT: tier1_limit_r <= cfg_data;
          REG_TIER2_LIMIT: tier2_limit_r <= cfg_data;
          default: begin
            tier1_limit_r <= tier1_limit_r;
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_exec_mode    = out_mode_r;
  assign out_promoted_to  = out_promo_r;
  assign out_call_count   = out_count_r;
  assign out_entry_slot   = out_slot_r;
  assign out_was_inserted = out_ins_r;

  // The occupancy count never runs past the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    entries_used_r <= CNT_W'(TABLE_DEPTH))
    else $error("occupancy count exceeds table depth");

  // A rejection is only issued when every slot is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reject |-> status.full)
    else $error("rejection while table has free slots");

  // An insertion grows the table by exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> entries_used_r == $past(entries_used_r) + 1'b1)
    else $error("insertion did not advance occupancy");

  // Every accepted call reports a count of at least one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r != MODE_FULL) |-> out_count_r != '0)
    else $error("accepted call reports zero count");

  // Only one result per update or rejection.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.update || cmd.reject))
    else $error("result strobe without a finished item");

endmodule

### sv/tiered_hotness_counter_table.sv
// Top level of the tiered hotness counter table: connects the controller
// and the datapath. Depends on thct_pkg, thct_ctrl and thct_datapath.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ------------------------------------
//   input     start, busy               in_method_key
//   result    out_valid (strobe)        out_exec_mode, out_promoted_to,
//                                       out_call_count, out_entry_slot,
//                                       out_was_inserted
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// An item found at slot k is finished sooner than one found further on; a new
// key or a rejection first scans every entry in use, so a full 64 entry table
// costs the most per item. The time is set by the scan, which reads the key
// memory one slot per cycle through its single registered read port.
// Reset clears the occupancy count, the scan and the state machine and loads
// the limits with 1000 and 10000; the memories need no clearing pass because
// only slots below the occupancy count are ever read. The result strobe lasts
// one cycle and cannot be stalled; a new item may start in that same cycle.
module tiered_hotness_counter_table
  import thct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_W-1:0]      in_method_key,
  // Result items.
  output logic                  out_valid,
  output logic [MODE_W-1:0]     out_exec_mode,
  output logic [MODE_W-1:0]     out_promoted_to,
  output logic [COUNT_W-1:0]    out_call_count,
  output logic [SLOT_W-1:0]     out_entry_slot,
  output logic                  out_was_inserted,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  thct_cmd_t    cmd;
  thct_status_t status;

  // Limit registers can be written in any cycle.
  assign cfg_ready = 1'b1;

  // The controller walks each item through scan, then update or rejection.
  thct_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // The datapath holds the table and turns each command into memory traffic.
  thct_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_method_key    (in_method_key),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_exec_mode    (out_exec_mode),
    .out_promoted_to  (out_promoted_to),
    .out_call_count   (out_call_count),
    .out_entry_slot   (out_entry_slot),
    .out_was_inserted (out_was_inserted)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tiered_hotness_counter_table: drives method keys
// and limit writes, predicts each result and compares it. Depends on thct_pkg.
module tb;
  import thct_pkg::*;

  // Cycles to let pass once the last expected result is in. This covers one
  // worst case scan of a full table plus some slack.
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

  // One result item as the block presents it.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [MODE_W-1:0]  promo;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  slot;
    logic               inserted;
  } call_result_t;

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  start            = 1'b0;
  logic [KEY_W-1:0]      in_method_key    = '0;
  logic                  cfg_valid        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = REG_TIER1_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  busy;
  logic                  out_valid;
  logic [MODE_W-1:0]     out_exec_mode;
  logic [MODE_W-1:0]     out_promoted_to;
  logic [COUNT_W-1:0]    out_call_count;
  logic [SLOT_W-1:0]     out_entry_slot;
  logic                  out_was_inserted;
  logic                  cfg_ready;

  tiered_hotness_counter_table u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_method_key    (in_method_key),
    .out_valid        (out_valid),
    .out_exec_mode    (out_exec_mode),
    .out_promoted_to  (out_promoted_to),
    .out_call_count   (out_call_count),
    .out_entry_slot   (out_entry_slot),
    .out_was_inserted (out_was_inserted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Our own copy of the method table and the limit registers. The table is
  // only ever read below the occupancy count, just as in the block.
  logic [KEY_W-1:0]   method_keys   [TABLE_DEPTH];
  logic [COUNT_W-1:0] method_counts [TABLE_DEPTH];
  logic [MODE_W-1:0]  method_tiers  [TABLE_DEPTH];
  int                 slots_used    = 0;
  logic [COUNT_W-1:0] tier1_limit   = TIER1_LIMIT_RST;
  logic [COUNT_W-1:0] tier2_limit   = TIER2_LIMIT_RST;

  // Results still owed by the block, oldest first.
  call_result_t pending_results [$];

  int  n_calls    = 0;
  int  n_checked  = 0;
  int  n_promos   = 0;
  int  n_rejects  = 0;
  int  n_inserts  = 0;
  int  n_errors   = 0;
  // When set, the sender issues items back to back with no gaps.
  bit  quiet      = 1'b0;

  // Works out the result of one invocation and updates the table copy.
  // A miss on a full table is rejected with every other field zero and no
  // change of state. The count saturates, and the threshold compare uses the
  // saturated value, so a limit of 65535 is still reached.
  function automatic call_result_t count_invocation(input logic [KEY_W-1:0] key);
    call_result_t       res;
    int                 slot;
    logic [COUNT_W-1:0] cnt;
    res  = '0;
    slot = -1;
    for (int i = 0; i < slots_used; i++) begin
      if (method_keys[i] == key) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      if (slots_used >= TABLE_DEPTH) begin
        res.mode = MODE_FULL;
        n_rejects++;
        return res;
      end
      slot                = slots_used;
      method_keys[slot]   = key;
      method_counts[slot] = '0;
      method_tiers[slot]  = MODE_INTERP;
      slots_used++;
      res.inserted = 1'b1;
      n_inserts++;
    end
    cnt = method_counts[slot];
    if (cnt != COUNT_MAX) cnt++;
    method_counts[slot] = cnt;
    // The reported mode is the tier before any promotion by this call.
    res.mode  = method_tiers[slot];
    res.promo = PROMO_NONE;
    if (res.mode == MODE_INTERP && cnt >= tier1_limit) begin
      method_tiers[slot] = MODE_TIER1;
      res.promo          = PROMO_TIER1;
    end else if (res.mode == MODE_TIER1 && cnt >= tier2_limit) begin
      method_tiers[slot] = MODE_TIER2;
      res.promo          = PROMO_TIER2;
    end
    if (res.promo != PROMO_NONE) n_promos++;
    res.count = cnt;
    res.slot  = SLOT_W'(slot);
    return res;
  endfunction

  function automatic bit key_known(input logic [KEY_W-1:0] key);
    for (int i = 0; i < slots_used; i++) begin
      if (method_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] key;
    key = $urandom();
    while (key_known(key)) key = $urandom();
    return key;
  endfunction

  // Random key: mostly keys already in the table, with a bias toward the
  // most recently inserted ones so that they climb the tiers. New keys are
  // either fully random or one bit away from a stored key, which exercises
  // the key compare on near misses.
  function automatic logic [KEY_W-1:0] pick_key(input int pct_new);
    logic [KEY_W-1:0] key;
    int               hot;
    if (slots_used == 0) return $urandom();
    hot = (slots_used < 6) ? slots_used : 6;
    if ($urandom_range(0, 99) < pct_new) begin
      if ($urandom_range(0, 1) == 0) key = $urandom();
      else key = method_keys[$urandom_range(0, slots_used - 1)]
                 ^ (32'd1 << $urandom_range(0, KEY_W - 1));
    end else if ($urandom_range(0, 1) == 0) begin
      key = method_keys[slots_used - 1 - $urandom_range(0, hot - 1)];
    end else begin
      key = method_keys[$urandom_range(0, slots_used - 1)];
    end
    return key;
  endfunction

  function automatic int sender_gap();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  // Sends one item. Start stays high after acceptance so that a following
  // item with no gap goes out back to back; it is lowered only when a gap
  // is wanted, at the step where the previous item was taken.
  task automatic call_method(input logic [KEY_W-1:0] key, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_method_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(count_invocation(key));
    n_calls++;
  endtask

  // Stops sending and waits until every owed result is in, then lets a scan's
  // worth of cycles go by so the block is idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both limits back to back; valid stays high across the two writes.
  task automatic set_limits(input logic [COUNT_W-1:0] lim1, input logic [COUNT_W-1:0] lim2);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TIER1_LIMIT;
    cfg_data  <= lim1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tier1_limit = lim1;
    cfg_index <= REG_TIER2_LIMIT;
    cfg_data  <= lim2;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tier2_limit = lim2;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] expd,
                             input logic [31:0] got);
    if (got !== expd) begin
      $error("%s mismatch: expected %0d, got %0d", name, expd, got);
      n_errors++;
    end
  endtask

  // Result checker. Each strobed result is matched against the oldest
  // prediction; a strobe with nothing owed is an error of its own.
  always @(posedge clk) begin
    call_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("exec_mode", 32'(want.mode), 32'(out_exec_mode));
        check_field("promoted_to", 32'(want.promo), 32'(out_promoted_to));
        check_field("call_count", 32'(want.count), 32'(out_call_count));
        check_field("entry_slot", 32'(want.slot), 32'(out_entry_slot));
        check_field("was_inserted", 32'(want.inserted), 32'(out_was_inserted));
        n_checked++;
      end
    end
  end

  // First items after reset run on the reset limits. Key zero lands in
  // slot 0 and the all-ones key in slot 1. Repeats show hits at low and
  // higher slots.
  task automatic test_first_calls();
    call_method(32'h0000_0000, 0);
    call_method(32'hFFFF_FFFF, 0);
    call_method(32'h0000_0000, 1);
    call_method(32'h8000_0001, 0);
    call_method(32'hFFFF_FFFF, 3);
    call_method(32'h7FFF_FFFE, 0);
    call_method(32'h8000_0001, 0);
    call_method(32'h0000_0000, 5);
  endtask

  // Limits of zero: every count after an increment passes, so an entry moves
  // up one tier per call until it reaches tier two. Older entries still in
  // tier zero move on their next call as well.
  task automatic test_zero_limits();
    settle();
    set_limits('0, '0);
    repeat (3) call_method(32'h5A5A_5A5A, 0);
    call_method(32'h8000_0001, 2);
    call_method(32'h8000_0001, 0);
    call_method(32'h0000_0000, 0);
    call_method(32'hA5A5_A5A5, 4);
    call_method(32'hA5A5_A5A5, 0);
  endtask

  // Random traffic on a table that is not full yet, under several limit
  // settings, one of them with the tier two limit below the tier one limit.
  task automatic test_random_calls();
    logic [COUNT_W-1:0] lim1 [4] = '{16'd3, 16'd1, 16'd5, 16'd4};
    logic [COUNT_W-1:0] lim2 [4] = '{16'd6, 16'd2, 16'd5, 16'd2};
    for (int p = 0; p < 4; p++) begin
      settle();
      set_limits(lim1[p], lim2[p]);
      quiet = (p == 1);
      repeat (60) call_method(pick_key(10), sender_gap());
    end
    quiet = 1'b0;
  endtask

  // Fills the remaining slots with new keys, then sends new keys that must be
  // rejected, mixed with hits on the last and the first slot.
  task automatic test_table_full();
    settle();
    set_limits(16'd2, 16'd4);
    while (slots_used < TABLE_DEPTH) call_method(fresh_key(), sender_gap());
    call_method(fresh_key(), 0);
    call_method(method_keys[TABLE_DEPTH - 1], 0);
    call_method(fresh_key(), 2);
    call_method(method_keys[0], 0);
    call_method(fresh_key(), 0);
  endtask

  // Random traffic on the full table: hits anywhere in the scan range and
  // rejected misses, under two random limit settings.
  task automatic test_random_full();
    for (int p = 0; p < 2; p++) begin
      settle();
      set_limits(COUNT_W'($urandom_range(1, 8)), COUNT_W'($urandom_range(1, 12)));
      quiet = (p == 1);
      repeat (100) call_method(pick_key(35), sender_gap());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_calls();
    test_zero_limits();
    test_random_calls();
    test_table_full();
    test_random_full();

    // Wait for the last results plus a scan's worth of quiet cycles; any
    // stray strobe in that window is caught by the checker.
    settle();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_errors++;
    end

    $display("Ran %0d method calls (%0d new entries, %0d table-full rejects).",
             n_calls, n_inserts, n_rejects);
    $display("Checked %0d results, saw %0d promotions, %0d mismatches.",
             n_checked, n_promos, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog. A correct run spends most of its time in scans of the full
  // table; this timeout allows many times the length of such a run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
